// ----- rtl/rfae_pkg.sv -----
// Shared types, constants and helpers for the register-file execute block.
// No dependencies; every other file of the block but rfae_ram refers to it by scoped names.
package rfae_pkg;

   localparam int NUM_REGS  = 32;
   localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int DATA_W    = 64;
   localparam int HALF_W    = DATA_W / 2;
   localparam int OP_W      = 4;
   localparam int IDX_W     = 5;

   typedef enum logic [OP_W-1:0] {
      OP_ADD,
      OP_SUB,
      OP_SHL,
      OP_GT,
      OP_GE,
      OP_LT,
      OP_NE,
      OP_OR,
      OP_AND,
      OP_SELEV,
      OP_MUL,
      OP_MULADD,
      OP_MOV,
      OP_SELECT
   } op_type;

   typedef enum logic [1:0] {
      EXE_IDLE,
      EXE_READ,
      EXE_MUL
   } exe_state_type;

   typedef enum logic [2:0] {
      MUL_IDLE,
      MUL_LL,
      MUL_LH,
      MUL_HL,
      MUL_SUM,
      MUL_DONE
   } mul_state_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] addend;
   } mul_req_type;

   typedef struct packed {
      logic              defined;
      logic [DATA_W-1:0] value;
   } alu_result_type;

   // Register index folded into the file: small constant table over the field codes.
   function automatic logic [REG_IDX_W-1:0] reg_index(input logic [IDX_W-1:0] raw);
      logic [REG_IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < (1 << IDX_W); i++) begin
         if (raw == IDX_W'(i)) begin
            idx = REG_IDX_W'(i % NUM_REGS);
         end
      end
      return idx;
   endfunction

endpackage

// ----- rtl/rfae_if.sv -----
// Request and response channel interfaces (valid/ready) of the execute block.
// Depends on rfae_pkg for field widths.
interface rfae_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [rfae_pkg::OP_W-1:0]            operation;
   logic [rfae_pkg::IDX_W-1:0]           dest_index;
   logic [rfae_pkg::IDX_W-1:0]           source_index;
   logic signed [rfae_pkg::DATA_W-1:0]   operand_a;
   logic signed [rfae_pkg::DATA_W-1:0]   operand_b;

   modport source (output valid, operation, dest_index, source_index, operand_a, operand_b,
                   input ready);
   modport sink   (input valid, operation, dest_index, source_index, operand_a, operand_b,
                   output ready);
endinterface

interface rfae_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [rfae_pkg::IDX_W-1:0]           written_index;
   logic signed [rfae_pkg::DATA_W-1:0]   written_value;

   modport source (output valid, written_index, written_value, input ready);
   modport sink   (input valid, written_index, written_value, output ready);
endinterface

// ----- rtl/rfae_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rfae_ram #(
   parameter int  WIDTH  = 64,
   parameter int  DEPTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rfae_alu.sv -----
// Combinational operations of the execute block (everything but the multiplies).
// Depends on rfae_pkg.
module rfae_alu (
   input  rfae_pkg::op_type                op,
   input  logic [rfae_pkg::DATA_W-1:0]     operand_a,
   input  logic [rfae_pkg::DATA_W-1:0]     operand_b,
   input  logic [rfae_pkg::DATA_W-1:0]     rs,
   output rfae_pkg::alu_result_type        result
);

   logic a_gt_b;
   logic b_gt_a;

   assign a_gt_b = $signed(operand_a) > $signed(operand_b);
   assign b_gt_a = $signed(operand_b) > $signed(operand_a);

   always_comb begin
      result.defined = 1'b1;
      result.value   = '0;
      unique case (op) inside
         rfae_pkg::OP_ADD:    result.value = operand_a + operand_b;
         rfae_pkg::OP_SUB:    result.value = operand_a - operand_b;
         rfae_pkg::OP_SHL:    result.value = rs << operand_b[5:0];
         rfae_pkg::OP_GT:     result.value = rfae_pkg::DATA_W'(a_gt_b);
         rfae_pkg::OP_GE:     result.value = rfae_pkg::DATA_W'(!b_gt_a);
         rfae_pkg::OP_LT:     result.value = rfae_pkg::DATA_W'(b_gt_a);
         rfae_pkg::OP_NE:     result.value = rfae_pkg::DATA_W'(operand_a != operand_b);
         rfae_pkg::OP_OR:     result.value = operand_a | operand_b;
         rfae_pkg::OP_AND:    result.value = operand_a & operand_b;
         rfae_pkg::OP_SELEV:  result.value = rs[0] ? operand_b : operand_a;
         rfae_pkg::OP_MOV:    result.value = operand_a;
         rfae_pkg::OP_SELECT: result.value = (rs != '0) ? operand_a : operand_b;
         rfae_pkg::OP_MUL, rfae_pkg::OP_MULADD: result.value = '0; // multiplier unit
         default:             result.defined = 1'b0;
      endcase
   end

endmodule

// ----- rtl/rfae_mul.sv -----
// Iterative 64-bit multiply-add (low half) on one shared 32x32 multiplier.
// Depends on rfae_pkg.
module rfae_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  rfae_pkg::mul_req_type         mul_req,
   output logic                          done,
   output logic [rfae_pkg::DATA_W-1:0]   result
);

   localparam int HW = rfae_pkg::HALF_W;

   rfae_pkg::mul_state_type state_ff, state_in;
   logic [rfae_pkg::DATA_W-1:0] x_ff, x_in;
   logic [rfae_pkg::DATA_W-1:0] y_ff, y_in;
   logic [rfae_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic [rfae_pkg::DATA_W-1:0] prod_ff, prod_in;
   logic [HW-1:0]               mul_a;
   logic [HW-1:0]               mul_b;
   logic [rfae_pkg::DATA_W-1:0] product;
   logic [rfae_pkg::DATA_W-1:0] prod_shifted;

   assign product      = mul_a * mul_b;
   assign prod_shifted = {prod_ff[HW-1:0], {HW{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfae_pkg::MUL_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      mul_a    = x_ff[HW-1:0];
      mul_b    = y_ff[HW-1:0];
      unique case (state_ff)
         rfae_pkg::MUL_IDLE, rfae_pkg::MUL_DONE: begin
            if (mul_req.start) begin
               x_in     = mul_req.x;
               y_in     = mul_req.y;
               acc_in   = mul_req.addend;
               state_in = rfae_pkg::MUL_LL;
            end
         end
         rfae_pkg::MUL_LL: begin
            prod_in  = product;
            state_in = rfae_pkg::MUL_LH;
         end
         rfae_pkg::MUL_LH: begin
            mul_b    = y_ff[rfae_pkg::DATA_W-1:HW];
            acc_in   = acc_ff + prod_ff;
            prod_in  = product;
            state_in = rfae_pkg::MUL_HL;
         end
         rfae_pkg::MUL_HL: begin
            mul_a    = x_ff[rfae_pkg::DATA_W-1:HW];
            acc_in   = acc_ff + prod_shifted;
            prod_in  = product;
            state_in = rfae_pkg::MUL_SUM;
         end
         rfae_pkg::MUL_SUM: begin
            acc_in   = acc_ff + prod_shifted;
            state_in = rfae_pkg::MUL_DONE;
         end
         default: state_in = rfae_pkg::MUL_IDLE;
      endcase
   end

   assign done   = (state_ff == rfae_pkg::MUL_DONE);
   assign result = acc_ff;

endmodule

// ----- rtl/register_file_alu_execute.sv -----
// Register-file execute block: top level, control sequencer and response register.
// Depends on rfae_pkg, rfae_if, rfae_ram, rfae_alu and rfae_mul.

// Executes one instruction per request against a file of NUM_REGS signed 64-bit
// registers and returns one response (register written, value written) for every
// defined operation; operation codes 14 and 15 are accepted and dropped with no
// write and no response. The register file sits in a synchronous RAM with a
// registered read; per-entry valid flops, cleared by reset, make every
// register read as zero until it is first written, so no clearing pass is needed.
// Indices are folded into the file modulo NUM_REGS. One request is in flight at a
// time: after acceptance a non-multiply request reads the RAM, then executes and
// writes back before the next acceptance; mul and muladd also wait on rfae_mul,
// as the low 64 bits of the product are built from three passes through a
// shared 32x32 multiplier. A finished response waits in an output register while
// the next request is accepted; the block holds only if that register is still
// occupied when the following result is ready.
module register_file_alu_execute (
   input  logic        clock,
   input  logic        reset,
   rfae_req_if.sink    req_ch,
   rfae_rsp_if.source  rsp_ch
);

   // Request capture
   rfae_pkg::exe_state_type              state_ff, state_in;
   rfae_pkg::op_type                     op_ff, op_in;
   logic [rfae_pkg::REG_IDX_W-1:0]       dst_ff, dst_in;
   logic [rfae_pkg::REG_IDX_W-1:0]       src_ff, src_in;
   logic [rfae_pkg::DATA_W-1:0]          a_ff, a_in;
   logic [rfae_pkg::DATA_W-1:0]          b_ff, b_in;

   // Register file
   logic [rfae_pkg::NUM_REGS-1:0]        valid_ff, valid_in;
   logic                                 ram_wr_en;
   logic [rfae_pkg::DATA_W-1:0]          ram_wr_data;
   logic [rfae_pkg::REG_IDX_W-1:0]       ram_rd_addr;
   logic [rfae_pkg::DATA_W-1:0]          ram_rd_data;
   logic [rfae_pkg::DATA_W-1:0]          rs;

   // Execute units
   rfae_pkg::alu_result_type             alu_result;
   rfae_pkg::mul_req_type                mul_req;
   logic                                 mul_done;
   logic [rfae_pkg::DATA_W-1:0]          mul_result;
   logic                                 is_mul;

   // Response register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [rfae_pkg::IDX_W-1:0]           rsp_index_ff, rsp_index_in;
   logic [rfae_pkg::DATA_W-1:0]          rsp_value_ff, rsp_value_in;
   logic                                 rsp_load;
   logic                                 out_free;

   rfae_ram #(
      .WIDTH (rfae_pkg::DATA_W),
      .DEPTH (rfae_pkg::NUM_REGS)
   ) u_regs (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (dst_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rfae_alu u_alu (
      .op        (op_ff),
      .operand_a (a_ff),
      .operand_b (b_ff),
      .rs        (rs),
      .result    (alu_result)
   );

   rfae_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .done    (mul_done),
      .result  (mul_result)
   );

   // Never-written registers read as their reset value of zero.
   assign rs       = valid_ff[src_ff] ? ram_rd_data : '0;
   assign is_mul   = (op_ff == rfae_pkg::OP_MUL) || (op_ff == rfae_pkg::OP_MULADD);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == rfae_pkg::EXE_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfae_pkg::EXE_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      dst_ff       <= dst_in;
      src_ff       <= src_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      dst_in      = dst_ff;
      src_in      = src_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      ram_rd_addr = src_ff;
      ram_wr_en   = 1'b0;
      ram_wr_data = alu_result.value;
      rsp_load    = 1'b0;
      mul_req     = '0;

      unique case (state_ff)
         rfae_pkg::EXE_IDLE: begin
            // RAM read issued in the acceptance cycle; data lands for EXE_READ.
            ram_rd_addr = rfae_pkg::reg_index(req_ch.source_index);
            if (req_ch.valid) begin
               op_in    = rfae_pkg::op_type'(req_ch.operation);
               dst_in   = rfae_pkg::reg_index(req_ch.dest_index);
               src_in   = rfae_pkg::reg_index(req_ch.source_index);
               a_in     = req_ch.operand_a;
               b_in     = req_ch.operand_b;
               state_in = rfae_pkg::EXE_READ;
            end
         end
         rfae_pkg::EXE_READ: begin
            if (is_mul) begin
               mul_req.start  = 1'b1;
               mul_req.x      = (op_ff == rfae_pkg::OP_MUL) ? a_ff : rs;
               mul_req.y      = (op_ff == rfae_pkg::OP_MUL) ? b_ff : a_ff;
               mul_req.addend = (op_ff == rfae_pkg::OP_MULADD) ? b_ff : '0;
               state_in       = rfae_pkg::EXE_MUL;
            end else if (!alu_result.defined) begin
               state_in = rfae_pkg::EXE_IDLE;      // undefined code: dropped
            end else if (out_free) begin
               ram_wr_en = 1'b1;
               rsp_load  = 1'b1;
               state_in  = rfae_pkg::EXE_IDLE;
            end
         end
         rfae_pkg::EXE_MUL: begin
            ram_wr_data = mul_result;
            if (mul_done && out_free) begin
               ram_wr_en = 1'b1;
               rsp_load  = 1'b1;
               state_in  = rfae_pkg::EXE_IDLE;
            end
         end
         default: state_in = rfae_pkg::EXE_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (ram_wr_en) begin
         valid_in[dst_ff] = 1'b1;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_index_in = rsp_load ? rfae_pkg::IDX_W'(dst_ff) : rsp_index_ff;
   assign rsp_value_in = rsp_load ? ram_wr_data : rsp_value_ff;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.written_index = rsp_index_ff;
   assign rsp_ch.written_value = rsp_value_ff;

`ifndef SYNTHESIS
   // Every write-back is reported the cycle after.
   a_wr_reports: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> rsp_ch.valid)
      else $error("register write without a response");

   // Reported index is the register actually written.
   a_wr_index: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> (rsp_ch.written_index == rfae_pkg::IDX_W'($past(dst_ff))))
      else $error("response index differs from written register");

   // An accepted request always goes to the read stage.
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == rfae_pkg::EXE_READ))
      else $error("accepted request did not enter read stage");

   // Only multiplies wait on the multiplier.
   a_mul_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfae_pkg::EXE_MUL) |->
         ((op_ff == rfae_pkg::OP_MUL) || (op_ff == rfae_pkg::OP_MULADD)))
      else $error("non-multiply request in multiply state");
`endif

endmodule
